// ===== rtl/cigar_string_analyzer_assert.svh =====
// ----------------------------------------------------------------------------
// CIGAR string analyser: assertion macros
// Shared concurrent assertion forms, clocked and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CIGAR_STRING_ANALYZER_ASSERT_SVH
`define CIGAR_STRING_ANALYZER_ASSERT_SVH

// same-cycle implication
`define CSA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("CIGAR analyser check failed");

// next-cycle implication
`define CSA_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("CIGAR analyser check failed");

`endif

// ===== rtl/csa_pkg.sv =====
// ----------------------------------------------------------------------------
// CIGAR string analyser package
// Character codes, BAM opcodes, error codes and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package csa_pkg;

   localparam int RUN_W = 28;
   localparam int SUM_W = 32;

   localparam logic [RUN_W-1:0] MAX_RUN = 28'hFFF_FFFF;

   // ASCII
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;
   localparam logic [7:0] CHAR_STAR = 8'h2A;
   localparam logic [7:0] CHAR_M    = 8'h4D;
   localparam logic [7:0] CHAR_I    = 8'h49;
   localparam logic [7:0] CHAR_D    = 8'h44;
   localparam logic [7:0] CHAR_N    = 8'h4E;
   localparam logic [7:0] CHAR_S    = 8'h53;
   localparam logic [7:0] CHAR_H    = 8'h48;
   localparam logic [7:0] CHAR_P    = 8'h50;
   localparam logic [7:0] CHAR_EQ   = 8'h3D;
   localparam logic [7:0] CHAR_X    = 8'h58;

   // BAM opcodes
   localparam logic [3:0] OP_M    = 4'd0;
   localparam logic [3:0] OP_I    = 4'd1;
   localparam logic [3:0] OP_D    = 4'd2;
   localparam logic [3:0] OP_N    = 4'd3;
   localparam logic [3:0] OP_S    = 4'd4;
   localparam logic [3:0] OP_H    = 4'd5;
   localparam logic [3:0] OP_P    = 4'd6;
   localparam logic [3:0] OP_EQ   = 4'd7;
   localparam logic [3:0] OP_X    = 4'd8;
   localparam logic [3:0] OP_NONE = 4'd15;

   // error codes
   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_BAD_CHAR = 3'd1;
   localparam logic [2:0] ERR_NO_NUM   = 3'd2;
   localparam logic [2:0] ERR_TRAIL    = 3'd3;
   localparam logic [2:0] ERR_ZERO_Q   = 3'd4;
   localparam logic [2:0] ERR_OVERFLOW = 3'd5;

   typedef struct packed {
      logic       is_numeral;
      logic [3:0] digit;
      logic       is_star;
      logic       is_op;
      logic [3:0] opcode;
      logic       use_query;
      logic       use_ref;
      logic       is_indel;
      logic       is_clip;
   } char_class_type;

   typedef struct packed {
      logic             has_op;
      logic [3:0]       op_code;
      logic [RUN_W-1:0] op_length;
      logic [SUM_W-1:0] query_total;
      logic [SUM_W-1:0] reference_total;
      logic [SUM_W-1:0] both_total;
      logic [SUM_W-1:0] indel_total;
      logic [SUM_W-1:0] clip_total;
      logic [2:0]       error_code;
      logic             end_of_string;
   } rsp_type;

endpackage

// ===== rtl/csa_char_class.sv =====
// ----------------------------------------------------------------------------
// CIGAR character classifier
// Sorts one ASCII character into digit, star, operation letter or other.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csa_char_class
   import csa_pkg::*;
(
   input  logic [7:0]     text_char,
   output char_class_type cls
);

   logic [7:0] digit_wide;

   assign digit_wide = text_char - CHAR_ZERO;

   always_comb begin
      cls            = '0;
      cls.is_numeral = (text_char >= CHAR_ZERO) && (text_char <= CHAR_NINE);
      cls.digit      = digit_wide[3:0];
      cls.is_star    = (text_char == CHAR_STAR);
      unique case (text_char)
         CHAR_M:  cls.opcode = OP_M;
         CHAR_I:  cls.opcode = OP_I;
         CHAR_D:  cls.opcode = OP_D;
         CHAR_N:  cls.opcode = OP_N;
         CHAR_S:  cls.opcode = OP_S;
         CHAR_H:  cls.opcode = OP_H;
         CHAR_P:  cls.opcode = OP_P;
         CHAR_EQ: cls.opcode = OP_EQ;
         CHAR_X:  cls.opcode = OP_X;
         default: cls.opcode = OP_NONE;
      endcase
      cls.is_op     = (cls.opcode != OP_NONE);
      // SAM consume rules
      cls.use_query = (cls.opcode == OP_M) || (cls.opcode == OP_I) || (cls.opcode == OP_S)
                      || (cls.opcode == OP_EQ) || (cls.opcode == OP_X);
      cls.use_ref   = (cls.opcode == OP_M) || (cls.opcode == OP_D) || (cls.opcode == OP_N)
                      || (cls.opcode == OP_EQ) || (cls.opcode == OP_X);
      cls.is_indel  = (cls.opcode == OP_I) || (cls.opcode == OP_D);
      cls.is_clip   = (cls.opcode == OP_S);
   end

endmodule

// ===== rtl/csa_core.sv =====
// ----------------------------------------------------------------------------
// CIGAR analyser core
// Run-length and total registers, per-character update and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csa_core
   import csa_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           item_valid,
   input  char_class_type cls,
   input  logic           last_char,
   input  logic           emit_ops,
   input  logic           rsp_ready,
   output logic           can_step,
   output logic           rsp_valid,
   output rsp_type        rsp
);

   logic [RUN_W-1:0] run_ff,   run_in;
   logic [SUM_W-1:0] query_ff, query_in;
   logic [SUM_W-1:0] ref_ff,   ref_in;
   logic [SUM_W-1:0] both_ff,  both_in;
   logic [SUM_W-1:0] indel_ff, indel_in;
   logic [SUM_W-1:0] clip_ff,  clip_in;
   logic [2:0]       err_ff,   err_in;
   logic             start_ff, start_in;
   logic             star_ff,  star_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff,   rsp_in;

   logic [SUM_W-1:0] run_ext;
   logic [SUM_W-1:0] run_next;
   logic             has_op;
   logic             emit_now;
   logic             step;

   assign run_ext  = {{(SUM_W-RUN_W){1'b0}}, run_ff};
   // acc * 10 + d, never beyond 32 bits for a 28-bit accumulator
   assign run_next = (run_ext << 3) + (run_ext << 1) + {{(SUM_W-4){1'b0}}, cls.digit};

   always_comb begin
      run_in   = run_ff;
      query_in = query_ff;
      ref_in   = ref_ff;
      both_in  = both_ff;
      indel_in = indel_ff;
      clip_in  = clip_ff;
      err_in   = err_ff;
      star_in  = star_ff;
      start_in = 1'b0;
      has_op   = 1'b0;

      if (err_ff == ERR_NONE) begin
         priority if (star_ff) begin
            err_in = ERR_BAD_CHAR;
         end else if (cls.is_star) begin
            if (start_ff) star_in = 1'b1;
            else          err_in  = ERR_BAD_CHAR;
         end else if (cls.is_numeral) begin
            if (run_next > {{(SUM_W-RUN_W){1'b0}}, MAX_RUN}) begin
               err_in = ERR_OVERFLOW;
               run_in = MAX_RUN;
            end else begin
               run_in = run_next[RUN_W-1:0];
            end
         end else if (cls.is_op) begin
            if (run_ff == '0) begin
               err_in = ERR_NO_NUM;
            end else begin
               if (cls.use_query)               query_in = query_ff + run_ext;
               if (cls.use_ref)                 ref_in   = ref_ff + run_ext;
               if (cls.use_query && cls.use_ref) both_in  = both_ff + run_ext;
               if (cls.is_indel)                indel_in = indel_ff + run_ext;
               if (cls.is_clip)                 clip_in  = clip_ff + run_ext;
               has_op = emit_ops;
               run_in = '0;
            end
         end else begin
            err_in = ERR_BAD_CHAR;
         end
      end

      // end-of-string checks on the updated values
      if (last_char && (err_in == ERR_NONE)) begin
         if (run_in != '0)                    err_in = ERR_TRAIL;
         else if (!star_in && query_in == '0) err_in = ERR_ZERO_Q;
      end

      rsp_in.has_op          = has_op;
      rsp_in.op_code         = has_op ? cls.opcode : 4'd0;
      rsp_in.op_length       = has_op ? run_ff : '0;
      rsp_in.query_total     = query_in;
      rsp_in.reference_total = ref_in;
      rsp_in.both_total      = both_in;
      rsp_in.indel_total     = indel_in;
      rsp_in.clip_total      = clip_in;
      rsp_in.error_code      = err_in;
      rsp_in.end_of_string   = last_char;
   end

   assign emit_now = has_op || last_char;
   assign can_step = !emit_now || !rsp_valid_ff || rsp_ready;
   assign step     = item_valid && can_step;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step && emit_now)  rsp_valid_in = 1'b1;
      else if (rsp_ready)    rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && last_char)) begin
         run_ff   <= '0;
         query_ff <= '0;
         ref_ff   <= '0;
         both_ff  <= '0;
         indel_ff <= '0;
         clip_ff  <= '0;
         err_ff   <= ERR_NONE;
         start_ff <= 1'b1;
         star_ff  <= 1'b0;
      end else if (step) begin
         run_ff   <= run_in;
         query_ff <= query_in;
         ref_ff   <= ref_in;
         both_ff  <= both_in;
         indel_ff <= indel_in;
         clip_ff  <= clip_in;
         err_ff   <= err_in;
         start_ff <= start_in;
         star_ff  <= star_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (step && emit_now) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== rtl/cigar_string_analyzer.sv =====
// ----------------------------------------------------------------------------
// CIGAR string analyser
// Streams a textual SAM CIGAR and returns BAM operation words and totals.
// ----------------------------------------------------------------------------
// One CIGAR character is taken per item on the req_ stream, with tlast on the
// final character of the string. Each character is held in an input register,
// classified and applied to the run-length and total registers in a single pass,
// and any result lands in the rsp_ output register; with the result side ready
// the block takes one item every cycle, and an item that produces no result
// never waits for the output side. A result appears for every operation letter
// with a nonzero run before any error while csr_data was last written as 1
// (the reset value), and for every final character; tuser then flags whether
// the op fields are live and tlast marks the closing totals and error code.
// Errors are sticky to the end of the string, after which all string state clears.
// The user must write csr_data only while the block is idle; nothing enforces it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cigar_string_analyzer_assert.svh"

module cigar_string_analyzer
   import csa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // character stream
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] text_char
   input  logic         req_tlast,   // last_char
   // result stream
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [199:0] rsp_tdata,   // [3:0] op_code, [31:4] op_length,
                                     // [63:32] query_total, [95:64] reference_total,
                                     // [127:96] both_total, [159:128] indel_total,
                                     // [191:160] clip_total, [194:192] error_code,
                                     // [199:195] zero
   output logic         rsp_tuser,   // has_op
   output logic         rsp_tlast,   // end_of_string
   // control register: emit_binary_ops
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_data
);

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_char_ff;
   logic           in_last_ff;
   logic           emit_ff;
   logic           can_step;
   char_class_type cls;
   rsp_type        rsp;

   // --- control register ---
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset)          emit_ff <= 1'b1;
      else if (csr_valid) emit_ff <= csr_data;
   end

   // --- input register ---
   assign req_tready = !in_valid_ff || can_step;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) in_valid_in = req_tvalid;
   end

   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else       in_valid_ff <= in_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // --- classify and apply ---
   csa_char_class u_class (
      .text_char (in_char_ff),
      .cls       (cls)
   );

   csa_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (in_valid_ff),
      .cls        (cls),
      .last_char  (in_last_ff),
      .emit_ops   (emit_ff),
      .rsp_ready  (rsp_tready),
      .can_step   (can_step),
      .rsp_valid  (rsp_tvalid),
      .rsp        (rsp)
   );

   // --- result packing ---
   assign rsp_tdata = {5'b0, rsp.error_code, rsp.clip_total, rsp.indel_total,
                       rsp.both_total, rsp.reference_total, rsp.query_total,
                       rsp.op_length, rsp.op_code};
   assign rsp_tuser = rsp.has_op;
   assign rsp_tlast = rsp.end_of_string;

   // --- checks ---
   // an operation word always carries a real run length and opcode
   `CSA_ASSERT_IMP(a_op_nonzero, clock, reset, rsp_tvalid && rsp_tuser,
                   rsp_tdata[31:4] != 28'd0 && rsp_tdata[3:0] <= OP_X)
   // a result without an operation is only ever the closing totals
   `CSA_ASSERT_IMP(a_plain_is_end, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tlast)
   // op fields are zero when no operation is carried
   `CSA_ASSERT_IMP(a_idle_op_zero, clock, reset, rsp_tvalid && !rsp_tuser,
                   rsp_tdata[31:0] == 32'd0)
   // an item taken on the req_ stream is in the input register next cycle
   `CSA_ASSERT_NXT(a_in_loaded, clock, reset, req_tvalid && req_tready, in_valid_ff)

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// CIGAR string analyser testbench
// Streams CIGAR strings one character per item into the block and checks
// every result against a cycle-free predictor of the parser, with random
// gaps and stalls on both streams and both settings of emit_binary_ops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import csa_pkg::*;

   // ------------------------------------------------------------------------
   // constants
   // ------------------------------------------------------------------------
   localparam int unsigned RUN_LIMIT    = 32'h0FFF_FFFF; // largest 28-bit run
   localparam int          SETTLE_TICKS = 8;     // covers the two-stage pipe
   localparam int          LONG_HOLD    = 300;   // one long result-side stall
   localparam int          STALL_LIMIT  = 2000;  // cycles without any handshake

   typedef struct packed {
      logic [7:0] ch;
      logic       fin;
   } text_item_type;

   // ------------------------------------------------------------------------
   // block ports; the inputs driven here are known from time zero
   // ------------------------------------------------------------------------
   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata  = 8'd0;   // [7:0] text_char
   logic         req_tlast  = 1'b0;   // last_char
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [199:0] rsp_tdata;           // [3:0] op_code, [31:4] op_length,
                                      // [63:32] query_total, [95:64] reference_total,
                                      // [127:96] both_total, [159:128] indel_total,
                                      // [191:160] clip_total, [194:192] error_code
   logic         rsp_tuser;           // has_op
   logic         rsp_tlast;           // end_of_string
   logic         csr_valid  = 1'b0;
   logic         csr_ready;
   logic         csr_data   = 1'b0;

   cigar_string_analyzer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // shared state
   // ------------------------------------------------------------------------
   text_item_type char_queue[$];   // characters waiting for the driver
   rsp_type     predicted_rsp[$];  // results still owed by the block
   int unsigned queued_chars = 0;
   int          failures     = 0;
   bit          quiet_tail    = 1'b0; // no new gaps or stalls from here on
   bit          long_hold_req = 1'b0;
   bit          long_hold_done = 1'b0;
   int          src_gap  = 0;
   int          sink_gap = 0;
   int          idle_cycles = 0;

   // predictor copy of the register and of the per-string state
   logic             emit_ops   = 1'b1;
   logic [RUN_W-1:0] run_len    = '0;
   logic [SUM_W-1:0] q_sum      = '0;
   logic [SUM_W-1:0] r_sum      = '0;
   logic [SUM_W-1:0] qr_sum     = '0;
   logic [SUM_W-1:0] indel_sum  = '0;
   logic [SUM_W-1:0] clip_sum   = '0;
   logic [2:0]       sticky_err = ERR_NONE;
   logic             at_start   = 1'b1;
   logic             star_open  = 1'b0;

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------
   function automatic logic [3:0] bam_opcode(input logic [7:0] ch);
      case (ch)
         CHAR_M:  return OP_M;
         CHAR_I:  return OP_I;
         CHAR_D:  return OP_D;
         CHAR_N:  return OP_N;
         CHAR_S:  return OP_S;
         CHAR_H:  return OP_H;
         CHAR_P:  return OP_P;
         CHAR_EQ: return OP_EQ;
         CHAR_X:  return OP_X;
         default: return OP_NONE;
      endcase
   endfunction

   function automatic logic [7:0] op_letter(input int idx);
      case (idx)
         0:       return CHAR_M;
         1:       return CHAR_I;
         2:       return CHAR_D;
         3:       return CHAR_N;
         4:       return CHAR_S;
         5:       return CHAR_H;
         6:       return CHAR_P;
         7:       return CHAR_EQ;
         default: return CHAR_X;
      endcase
   endfunction

   // Applies one character to the predicted state; returns 1 when the block
   // owes a result for it, which is then left in res.
   function automatic bit parse_cigar_char(input logic [7:0] ch, input logic fin,
                                           output rsp_type res);
      logic [3:0]  op;
      logic        first;
      logic        q_use;
      logic        r_use;
      logic [31:0] digit;
      logic [31:0] run_wide;
      bit          owed;

      res      = '0;
      first    = at_start;
      at_start = 1'b0;
      op       = bam_opcode(ch);
      digit    = {24'd0, ch - CHAR_ZERO};
      run_wide = {4'd0, run_len};

      if (sticky_err == ERR_NONE) begin
         if (star_open) begin
            sticky_err = ERR_BAD_CHAR;           // nothing may follow a lone star
         end else if (ch == CHAR_STAR) begin
            if (first) star_open = 1'b1;
            else sticky_err = ERR_BAD_CHAR;
         end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
            if (run_wide > (RUN_LIMIT - digit) / 10) begin
               sticky_err = ERR_OVERFLOW;
               run_len    = RUN_LIMIT[RUN_W-1:0];
            end else begin
               run_len = RUN_W'(run_wide * 10 + digit);
            end
         end else if (op != OP_NONE) begin
            if (run_len == '0) begin
               sticky_err = ERR_NO_NUM;
            end else begin
               q_use = op inside {OP_M, OP_I, OP_S, OP_EQ, OP_X};
               r_use = op inside {OP_M, OP_D, OP_N, OP_EQ, OP_X};
               if (q_use) q_sum = q_sum + run_wide;
               if (r_use) r_sum = r_sum + run_wide;
               if (q_use && r_use) qr_sum = qr_sum + run_wide;
               if (op == OP_I || op == OP_D) indel_sum = indel_sum + run_wide;
               else if (op == OP_S) clip_sum = clip_sum + run_wide;
               if (emit_ops) begin
                  res.has_op    = 1'b1;
                  res.op_code   = op;
                  res.op_length = run_len;
               end
               run_len = '0;
            end
         end else begin
            sticky_err = ERR_BAD_CHAR;
         end
      end

      // closing checks on the final character
      if (fin && sticky_err == ERR_NONE) begin
         if (run_len != '0) sticky_err = ERR_TRAIL;
         else if (!star_open && q_sum == '0) sticky_err = ERR_ZERO_Q;
      end

      res.query_total     = q_sum;
      res.reference_total = r_sum;
      res.both_total      = qr_sum;
      res.indel_total     = indel_sum;
      res.clip_total      = clip_sum;
      res.error_code      = sticky_err;
      res.end_of_string   = fin;
      owed = res.has_op || fin;

      if (fin) begin
         run_len    = '0;
         q_sum      = '0;
         r_sum      = '0;
         qr_sum     = '0;
         indel_sum  = '0;
         clip_sum   = '0;
         sticky_err = ERR_NONE;
         at_start   = 1'b1;
         star_open  = 1'b0;
      end
      return owed;
   endfunction

   // ------------------------------------------------------------------------
   // driver: feeds the character stream, random gaps after accepted items
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      text_item_type nxt;
      rsp_type       res;
      if (reset) begin
         req_tvalid <= 1'b0;
         src_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (parse_cigar_char(req_tdata, req_tlast, res)) predicted_rsp.push_back(res);
            if (!quiet_tail && $urandom_range(0, 9) == 0) src_gap = $urandom_range(1, 17);
         end
         // slot is free once the current item has gone, or if none was offered
         if (!req_tvalid || req_tready) begin
            if (src_gap != 0) begin
               src_gap--;
               req_tvalid <= 1'b0;
            end else if (char_queue.size() != 0) begin
               nxt = char_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= nxt.ch;
               req_tlast  <= nxt.fin;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // monitor: checks results, random stalls and one long hold-off
   // ------------------------------------------------------------------------
   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         sink_gap = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_rsp.size() == 0) begin
               $error("result item arrived with none outstanding");
               failures++;
            end else begin
               want = predicted_rsp.pop_front();
               check_field("has_op",          want.has_op,          rsp_tuser);
               check_field("op_code",         want.op_code,         rsp_tdata[3:0]);
               check_field("op_length",       want.op_length,       rsp_tdata[31:4]);
               check_field("query_total",     want.query_total,     rsp_tdata[63:32]);
               check_field("reference_total", want.reference_total, rsp_tdata[95:64]);
               check_field("both_total",      want.both_total,      rsp_tdata[127:96]);
               check_field("indel_total",     want.indel_total,     rsp_tdata[159:128]);
               check_field("clip_total",      want.clip_total,      rsp_tdata[191:160]);
               check_field("error_code",      want.error_code,      rsp_tdata[194:192]);
               check_field("end_of_string",   want.end_of_string,   rsp_tlast);
            end
         end
         if (long_hold_req && !long_hold_done) begin
            sink_gap = LONG_HOLD;      // block fills up and backs onto its input
            long_hold_done = 1'b1;
         end else if (sink_gap == 0 && !quiet_tail && $urandom_range(0, 11) == 0) begin
            sink_gap = $urandom_range(1, 17);
         end
         if (sink_gap != 0) begin
            sink_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // watchdog: too long without any handshake on any channel
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("cigar_string_analyzer regression: fail");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus builders
   // ------------------------------------------------------------------------
   task automatic append_num(ref logic [7:0] txt[$], input int unsigned v);
      string s;
      s = $sformatf("%0d", v);
      for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
   endtask

   task automatic append_text(ref logic [7:0] txt[$], input string s);
      for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
   endtask

   // mostly short runs, now and then huge ones and the 28-bit maximum
   function automatic int unsigned rand_len();
      case ($urandom_range(0, 19))
         0:       return RUN_LIMIT;
         1, 2:    return $urandom_range(1, RUN_LIMIT);
         3:       return $urandom_range(100, 99999);
         default: return $urandom_range(1, 99);
      endcase
   endfunction

   // well-formed operations; no_query picks only D N H P
   task automatic build_ops(ref logic [7:0] txt[$], input int nops, input bit no_query);
      int pick;
      for (int i = 0; i < nops; i++) begin
         if ($urandom_range(0, 11) == 0) txt.push_back(CHAR_ZERO);   // leading zero
         append_num(txt, rand_len());
         if (no_query) begin
            case ($urandom_range(0, 3))
               0:       pick = 2;
               1:       pick = 3;
               2:       pick = 5;
               default: pick = 6;
            endcase
         end else begin
            pick = $urandom_range(0, 8);
         end
         txt.push_back(op_letter(pick));
      end
   endtask

   task automatic commit(ref logic [7:0] txt[$]);
      text_item_type it;
      for (int i = 0; i < txt.size(); i++) begin
         it.ch  = txt[i];
         it.fin = (i == txt.size() - 1);
         char_queue.push_back(it);
      end
      queued_chars += txt.size();
   endtask

   task automatic queue_text(input string s);
      logic [7:0] txt[$];
      append_text(txt, s);
      commit(txt);
   endtask

   task automatic queue_random_strings(input int target);
      logic [7:0]  txt[$];
      int          kind;
      int unsigned goal;
      goal = queued_chars + target;
      while (queued_chars < goal) begin
         txt.delete();
         kind = $urandom_range(0, 99);
         if (kind < 62) begin
            build_ops(txt, $urandom_range(1, 8), 1'b0);
         end else if (kind < 70) begin
            // one character overwritten with any byte
            build_ops(txt, $urandom_range(1, 6), 1'b0);
            txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
         end else if (kind < 75) begin
            // string ending in digits
            build_ops(txt, $urandom_range(0, 3), 1'b0);
            append_num(txt, $urandom_range(1, 999));
         end else if (kind < 80) begin
            // run length past 28 bits
            build_ops(txt, $urandom_range(0, 2), 1'b0);
            append_num(txt, $urandom_range(RUN_LIMIT + 1, 32'hFFFF_FFFF));
            if ($urandom_range(0, 1)) txt.push_back(op_letter($urandom_range(0, 8)));
         end else if (kind < 85) begin
            case ($urandom_range(0, 2))
               0: txt.push_back(CHAR_STAR);
               1: begin
                  txt.push_back(CHAR_STAR);
                  for (int i = $urandom_range(1, 3); i > 0; i--)
                     txt.push_back(8'($urandom_range(0, 255)));
               end
               default: begin
                  build_ops(txt, $urandom_range(1, 3), 1'b0);
                  txt.push_back(CHAR_STAR);
                  if ($urandom_range(0, 1)) build_ops(txt, 1, 1'b0);
               end
            endcase
         end else if (kind < 89) begin
            // letter with no run length, or a run of zeros
            build_ops(txt, $urandom_range(0, 3), 1'b0);
            for (int i = $urandom_range(0, 2); i > 0; i--) txt.push_back(CHAR_ZERO);
            txt.push_back(op_letter($urandom_range(0, 8)));
            if ($urandom_range(0, 1)) build_ops(txt, 1, 1'b0);
         end else if (kind < 93) begin
            build_ops(txt, $urandom_range(1, 4), 1'b1);   // nothing on the query
         end else begin
            for (int i = $urandom_range(1, 6); i > 0; i--)
               txt.push_back(8'($urandom_range(0, 255)));
         end
         commit(txt);
      end
   endtask

   // twenty maximum runs, which together pass 2^32
   task automatic queue_wrap_string();
      logic [7:0] txt[$];
      for (int i = 0; i < 20; i++) begin
         append_num(txt, RUN_LIMIT);
         case ($urandom_range(0, 5))
            0:       txt.push_back(CHAR_M);
            1:       txt.push_back(CHAR_I);
            2:       txt.push_back(CHAR_D);
            3:       txt.push_back(CHAR_S);
            4:       txt.push_back(CHAR_EQ);
            default: txt.push_back(CHAR_X);
         endcase
      end
      commit(txt);
   endtask

   // ------------------------------------------------------------------------
   // sequencing helpers
   // ------------------------------------------------------------------------
   // Everything fed, every result back, and the pipe given time to empty of
   // items that owe nothing.
   task automatic drain_block();
      do @(negedge clock);
      while (char_queue.size() != 0 || req_tvalid || predicted_rsp.size() != 0);
      repeat (SETTLE_TICKS) @(negedge clock);
   endtask

   task automatic write_emit(input logic v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock);
      while (!csr_ready);
      emit_ops = v;
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: emit_binary_ops at its reset value
      queue_text("*");                    // lone star: zero totals, no error
      queue_text("*M");                   // anything after a lone star
      queue_text("2M*");                  // star not at the start, then sticky
      queue_text("0M");                   // zero run length
      queue_text("4H");                   // nothing consumed on the query
      queue_text("7");                    // ends on a digit
      begin
         logic [7:0] txt[$];
         txt.push_back(8'hFF);            // top byte, not a CIGAR character
         commit(txt);
      end
      queue_text("1M2I3D4N5S6H7P8=9X");   // every operation letter
      queue_random_strings(200);
      drain_block();

      // op words off
      write_emit(1'b0);
      queue_random_strings(300);
      drain_block();

      // op words on, with a long result-side hold-off under a full input
      write_emit(1'b1);
      queue_wrap_string();
      queue_random_strings(150);
      long_hold_req = 1'b1;
      drain_block();

      // sender pauses here until all results are in, then carries on
      queue_random_strings(150);
      drain_block();

      write_emit(1'b0);
      queue_random_strings(300);
      drain_block();

      // closing stretch at full rate
      write_emit(1'b1);
      quiet_tail = 1'b1;
      queue_random_strings(220);
      drain_block();

      if (failures == 0)
         $display("cigar_string_analyzer regression: pass");
      else
         $display("cigar_string_analyzer regression: fail");
      $finish;
   end

endmodule
